### rtl/qws_pkg.sv
// Package for the quoted word splitter: byte codes, position limits,
// the classified byte type and the word phase encoding. No dependencies.
package qws_pkg;

  localparam int LINE_MAX = 1024;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;

  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(LINE_MAX - 1);
  localparam logic [CNT_W-1:0] ARGS_MAX = 7'd64;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;

  // One byte reduced to what the word tracker needs.
  typedef struct packed {
    logic nul;
    logic blank;
    logic dquote;
    logic squote;
  } cls_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WORD   = 2'd1,
    PH_QUOTED = 2'd2
  } phase_t;

endpackage

### rtl/qws_if.sv
// Valid/ready channel interfaces for the quoted word splitter.
// Depends on qws_pkg for field widths.
interface qws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source(output valid, output ch, input ready);
  modport sink(input valid, input ch, output ready);
endinterface

interface qws_out_if;
  logic                        valid;
  logic                        ready;
  logic                        word_valid;
  logic [qws_pkg::POS_W-1:0]   word_start;
  logic [qws_pkg::POS_W-1:0]   word_length;
  logic [qws_pkg::IDX_W-1:0]   word_index;
  logic                        line_done;
  logic [qws_pkg::CNT_W-1:0]   word_count;
  logic                        line_overflow;

  modport source(output valid, output word_valid, output word_start, output word_length,
                 output word_index, output line_done, output word_count,
                 output line_overflow, input ready);
  modport sink(input valid, input word_valid, input word_start, input word_length,
               input word_index, input line_done, input word_count,
               input line_overflow, output ready);
endinterface

### rtl/qws_front.sv
// Front end: takes byte transfers and classifies each byte for the queue.
// Depends on qws_pkg and qws_if.
module qws_front (
  qws_in_if.sink        chars,
  input  logic          full,
  output logic          push,
  output qws_pkg::cls_t item
);
  import qws_pkg::*;

  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  always_comb begin
    item.nul    = (chars.ch == CH_NUL);
    item.blank  = chars.ch inside {[CH_TAB:CH_CR], CH_SP};
    item.dquote = (chars.ch == CH_DQ);
    item.squote = (chars.ch == CH_SQ);
  end
endmodule

### rtl/qws_queue.sv
// Short FIFO of classified bytes between front and back end.
// Depends on qws_pkg.
module qws_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qws_pkg::cls_t din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output qws_pkg::cls_t dout
);
  import qws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cls_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign valid   = (fill != '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end
endmodule

### rtl/qws_back.sv
// Back end: word tracking state machine and the result output register.
// Depends on qws_pkg and qws_if.
module qws_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  qws_pkg::cls_t               q_item,
  output logic                        q_pop,
  input  logic [qws_pkg::CNT_W-1:0]   max_args,
  qws_out_if.source                   words
);
  import qws_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic               quote_single;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   word_begin;
  logic [CNT_W-1:0]   count;
  logic               overflowed;

  logic [CNT_W-1:0]   limit;
  logic               take;
  logic               under;
  logic               in_word;
  logic               ends_q;
  logic               pos_at_max;
  logic               is_quote;
  logic               end_word;
  logic               done_word;
  logic               emit;
  logic               r_valid;
  logic [POS_W-1:0]   r_len;
  logic [CNT_W-1:0]   r_count;
  logic               r_ovf;

  assign limit      = (max_args > ARGS_MAX) ? ARGS_MAX : max_args;
  assign take       = q_valid && (!words.valid || words.ready);
  assign q_pop      = take;
  assign under      = (count < limit);
  assign in_word    = (phase == PH_WORD) || (phase == PH_QUOTED);
  assign ends_q     = quote_single ? q_item.squote : q_item.dquote;
  assign pos_at_max = (position == POS_MAX);
  assign is_quote   = q_item.dquote || q_item.squote;

  // next phase
  always_comb begin
    phase_next = phase;
    if (q_item.nul) begin
      phase_next = PH_IDLE;
    end else if (under) begin
      case (phase)
        PH_WORD: begin
          if (q_item.blank) phase_next = PH_IDLE;
        end
        PH_QUOTED: begin
          if (ends_q) phase_next = PH_IDLE;
        end
        default: begin
          if (!q_item.blank) phase_next = is_quote ? PH_QUOTED : PH_WORD;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    end_word  = !q_item.nul && under &&
                (((phase == PH_WORD) && q_item.blank) || ((phase == PH_QUOTED) && ends_q));
    done_word = q_item.nul && in_word && under;
    emit      = end_word || q_item.nul;
    r_valid   = end_word || done_word;
    r_len     = (position >= word_begin) ? position - word_begin : '0;
    r_count   = r_valid ? count + CNT_W'(1) : count;
    r_ovf     = q_item.nul ? overflowed : (overflowed || pos_at_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      quote_single <= 1'b0;
      position     <= '0;
      word_begin   <= '0;
      count        <= '0;
      overflowed   <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      if (q_item.nul) begin
        quote_single <= 1'b0;
        position     <= '0;
        word_begin   <= '0;
        count        <= '0;
        overflowed   <= 1'b0;
      end else begin
        if (pos_at_max) begin
          overflowed <= 1'b1;
        end else begin
          position <= position + POS_W'(1);
        end
        if (end_word) begin
          count <= r_count;
        end
        if (under && !in_word && !q_item.blank) begin
          if (is_quote) begin
            quote_single <= q_item.squote;
            word_begin   <= pos_at_max ? POS_MAX : position + POS_W'(1);
          end else begin
            word_begin <= position;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      words.valid <= 1'b0;
    end else if (take && emit) begin
      words.valid <= 1'b1;
    end else if (words.ready) begin
      words.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      words.word_valid    <= r_valid;
      words.word_start    <= r_valid ? word_begin : '0;
      words.word_length   <= r_valid ? r_len : '0;
      words.word_index    <= r_valid ? count[IDX_W-1:0] : '0;
      words.line_done     <= q_item.nul;
      words.word_count    <= r_count;
      words.line_overflow <= r_ovf;
    end
  end
endmodule

### rtl/quoted_word_splitter.sv
// Top level of the quoted word splitter: config register, front end,
// byte queue and back end. Depends on qws_pkg, qws_if and the qws_* modules.
//
// Usage
//   chars : one byte of a command line per transfer; a zero byte ends the line.
//   words : one result per finished word, plus one per line terminator
//           (line_done = 1), which also carries any word still open at the end.
//   cfg_we/cfg_data : writes max_args (words to extract before the rest of
//           the line is skipped); values above 64 act as 64. Write only
//           while the block is idle.
// Timing
//   A byte transfer is registered into the byte queue, then passes through the
//   word tracker into the output register. Throughput is one byte per cycle
//   while a stalled result does not hold the back end, set by the state
//   update in the back end.
// Reset
//   rst empties the queue, clears the output valid and the line state,
//   and sets max_args to 64.
// Stall
//   While words.ready is low the output register holds its result; the back
//   end stops popping and the queue (QDEPTH bytes) keeps taking bytes until
//   full, at which point chars.ready drops.
module quoted_word_splitter #(
  parameter int QDEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qws_pkg::CNT_W-1:0]   cfg_data,
  qws_in_if.sink                      chars,
  qws_out_if.source                   words
);
  import qws_pkg::*;

  logic [CNT_W-1:0] max_args;   // word limit register

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cls_t f_item;                 // classified byte from the front end
  cls_t q_item;                 // head of the queue

  always_ff @(posedge clk) begin
    if (rst) begin
      max_args <= ARGS_MAX;
    end else if (cfg_we) begin
      max_args <= cfg_data;
    end
  end

  qws_front u_front (
    .chars (chars),
    .full  (q_full),
    .push  (q_push),
    .item  (f_item)
  );

  qws_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_item)
  );

  qws_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .max_args (max_args),
    .words    (words)
  );
endmodule

### rtl/qws_checker.sv
// Port-level checks for the quoted word splitter, bound to the top level.
// Depends on qws_pkg and quoted_word_splitter.
module qws_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        word_valid,
  input logic [qws_pkg::POS_W-1:0]   word_start,
  input logic [qws_pkg::POS_W-1:0]   word_length,
  input logic [qws_pkg::IDX_W-1:0]   word_index,
  input logic                        line_done,
  input logic [qws_pkg::CNT_W-1:0]   word_count
);
  import qws_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_start) && $stable(word_count)
      && $stable(line_done))
    else $error("result changed while stalled");

  // every result is a word or a line end
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> word_valid || line_done)
    else $error("empty result");

  // a word result counts itself
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_valid |-> word_count == CNT_W'(word_index) + CNT_W'(1))
    else $error("word count does not follow index");

  // line end with no word carries zero word fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word_valid |-> word_start == '0 && word_length == '0 && word_index == '0)
    else $error("nonzero word fields on empty line end");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind quoted_word_splitter qws_checker u_qws_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (words.valid),
  .out_ready   (words.ready),
  .word_valid  (words.word_valid),
  .word_start  (words.word_start),
  .word_length (words.word_length),
  .word_index  (words.word_index),
  .line_done   (words.line_done),
  .word_count  (words.word_count)
);

### bench/tb_top.sv
// Testbench for quoted_word_splitter: feeds command lines byte by byte and
// checks every word and line-done result against an internal tokenizer model.
// Depends on qws_pkg, qws_if (qws_in_if, qws_out_if) and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
  import qws_pkg::*;

  localparam int POS_LAST   = int'(POS_MAX);
  localparam int ARGS_LIMIT = int'(ARGS_MAX);
  localparam int CYCLE_CAP  = 200000;  // far above the slowest legal run
  localparam int DRAIN      = 8;       // byte queue and output register plus queue depth, with margin
  localparam int LONG_HOLD  = 300;     // receiver hold-off that backs up the byte queue

  // One result as it appears on the words channel.
  typedef struct packed {
    logic              word_valid;
    logic [POS_W-1:0]  word_start;
    logic [POS_W-1:0]  word_length;
    logic [IDX_W-1:0]  word_index;
    logic              line_done;
    logic [CNT_W-1:0]  word_count;
    logic              line_overflow;
  } word_res_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  qws_in_if  chars_if ();
  qws_out_if words_if ();

  quoted_word_splitter u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .chars    (chars_if),
    .words    (words_if)
  );

  // ---------------------------------------------------------------------------
  // Tokenizer model state: a private copy of the line tracker and max_args.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] max_args_m = ARGS_MAX;
  phase_t           ph         = PH_IDLE;
  bit               q_single   = 1'b0;
  int               line_pos   = 0;   // offset of the next byte
  int               word_beg   = 0;
  int               word_cnt   = 0;
  bit               ovf        = 1'b0;

  logic [7:0] pend_q[$];      // bytes waiting for the driver
  word_res_t  word_res_q[$];  // results predicted, not yet seen
  int         bytes_added = 0;
  int         err_cnt     = 0;
  int         cycles      = 0;

  // Driver and receiver control
  bit  offering   = 1'b0;   // a byte is on the channel and not yet taken
  int  burst_left = 1;
  int  gap_left   = 0;
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;
  int  rx_mode    = 0;
  int  rx_tick    = 0;

  word_res_t seen_exp;
  word_res_t pred_res;

  function automatic bit is_space(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SP;
  endfunction

  // Advance the model by one byte. Returns 1 when the byte yields a result.
  function automatic bit tokenize_byte(input logic [7:0] c, output word_res_t r);
    int lim;
    int p;
    bit ends;
    r   = '0;
    lim = (int'(max_args_m) > ARGS_LIMIT) ? ARGS_LIMIT : int'(max_args_m);
    p   = line_pos;

    // Terminator: flush any open word (if the limit allows), then reset the line.
    if (c == CH_NUL) begin
      if (ph != PH_IDLE && word_cnt < lim) begin
        r.word_valid  = 1'b1;
        r.word_start  = POS_W'(word_beg);
        r.word_length = POS_W'((p >= word_beg) ? p - word_beg : 0);
        r.word_index  = IDX_W'(word_cnt);
        word_cnt++;
      end
      r.line_done     = 1'b1;
      r.word_count    = CNT_W'(word_cnt);
      r.line_overflow = ovf;
      ph       = PH_IDLE;
      q_single = 1'b0;
      line_pos = 0;
      word_beg = 0;
      word_cnt = 0;
      ovf      = 1'b0;
      return 1'b1;
    end

    // Position saturates at the last offset; the byte is handled there.
    if (p >= POS_LAST) begin
      p   = POS_LAST;
      ovf = 1'b1;
    end else begin
      line_pos = p + 1;
    end

    // Limit reached: everything up to the terminator is skipped.
    if (word_cnt >= lim) return 1'b0;

    if (ph != PH_IDLE) begin
      if (ph == PH_WORD) ends = is_space(c);
      else ends = (c == (q_single ? CH_SQ : CH_DQ));
      if (!ends) return 1'b0;
      r.word_valid    = 1'b1;
      r.word_start    = POS_W'(word_beg);
      r.word_length   = POS_W'((p >= word_beg) ? p - word_beg : 0);
      r.word_index    = IDX_W'(word_cnt);
      word_cnt++;
      ph              = PH_IDLE;
      r.word_count    = CNT_W'(word_cnt);
      r.line_overflow = ovf;
      return 1'b1;
    end

    if (is_space(c)) return 1'b0;
    if (c == CH_DQ || c == CH_SQ) begin
      // Quoted word starts after the quote, saturated like the position.
      q_single = (c == CH_SQ);
      ph       = PH_QUOTED;
      word_beg = (p + 1 > POS_LAST) ? POS_LAST : p + 1;
    end else begin
      ph       = PH_WORD;
      word_beg = p;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte generators for well-formed and broken lines
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    pend_q.push_back(b);
    bytes_added++;
  endtask

  task automatic put_blanks();
    int n;
    int k;
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 1)) put_byte(CH_SP);
      else put_byte(8'($urandom_range(int'(CH_TAB), int'(CH_CR))));
    end
  endtask

  // Unquoted word opens with a plain byte; later bytes may be literal quotes.
  // Quoted word holds anything but NUL and its own quote, and is sometimes left open.
  task automatic put_word();
    logic [7:0] q;
    logic [7:0] c;
    int n;
    int k;
    if ($urandom_range(0, 2) == 0) begin
      q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
      put_byte(q);
      n = $urandom_range(0, 6);
      for (k = 0; k < n; k++) begin
        do c = 8'($urandom_range(1, 255)); while (c == q);
        put_byte(c);
      end
      if ($urandom_range(0, 7) != 0) put_byte(q);
    end else begin
      do c = 8'($urandom_range(1, 255)); while (is_space(c) || c == CH_SQ || c == CH_DQ);
      put_byte(c);
      n = $urandom_range(0, 5);
      for (k = 0; k < n; k++) begin
        do c = 8'($urandom_range(1, 255)); while (is_space(c));
        put_byte(c);
      end
    end
  endtask

  task automatic put_line(input int nwords, input bit terminate);
    int k;
    if ($urandom_range(0, 1)) put_blanks();
    for (k = 0; k < nwords; k++) begin
      put_word();
      if (k < nwords - 1 || $urandom_range(0, 1)) put_blanks();
    end
    if (terminate) put_byte(CH_NUL);
  endtask

  // Mostly well-formed lines; some with 62 to 70 words, around the largest limit, some noise.
  task automatic put_random_lines(input int n_bytes, input bit open_end);
    int stop_at;
    int kind;
    int n;
    int k;
    stop_at = bytes_added + n_bytes;
    while (bytes_added < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        n = $urandom_range(0, 30);
        for (k = 0; k < n; k++) put_byte(8'($urandom_range(1, 255)));
        put_byte(CH_NUL);
      end else if (kind == 2) begin
        put_line($urandom_range(62, 70), 1'b1);
      end else begin
        put_line($urandom_range(0, 8), 1'b1);
      end
    end
    // Leave a line open so the next limit lands mid-line.
    if (open_end) put_line(3, 1'b0);
  endtask

  // Block is idle once every byte went in, every result came out, and the
  // last no-result bytes have had time to pass through.
  task automatic wait_idle();
    while (pend_q.size() != 0 || offering || word_res_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_max_args(input int v);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CNT_W'(v);
    @(posedge clk);
    max_args_m = CNT_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: offers bytes from pend_q in bursts with random gaps. A byte stays
  // on the channel until its transfer, so valid is never dropped early.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
        chars_if.valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        chars_if.ch    <= pend_q.pop_front();
        chars_if.valid <= 1'b1;
        offering = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
  end

  // Byte transfer: run the model on it and queue any result it causes.
  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready) begin
      if (tokenize_byte(chars_if.ch, pred_res)) word_res_q.push_back(pred_res);
      offering = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows one of four patterns chosen at random; on request
  // it holds off long enough that the byte queue fills and chars stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      words_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
      words_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: words_if.ready <= 1'b1;
        1: words_if.ready <= 1'($urandom_range(0, 1));
        2: words_if.ready <= (rx_tick % 4 == 0);
        default: words_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result transfer: compare with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (!rst && words_if.valid && words_if.ready) begin
      if (word_res_q.size() == 0) begin
        $error("result with nothing predicted");
        err_cnt++;
      end else begin
        seen_exp = word_res_q.pop_front();
        check_field("word_valid", seen_exp.word_valid, words_if.word_valid);
        check_field("word_start", seen_exp.word_start, words_if.word_start);
        check_field("word_length", seen_exp.word_length, words_if.word_length);
        check_field("word_index", seen_exp.word_index, words_if.word_index);
        check_field("line_done", seen_exp.line_done, words_if.line_done);
        check_field("word_count", seen_exp.word_count, words_if.word_count);
        check_field("line_overflow", seen_exp.line_overflow, words_if.line_overflow);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    chars_if.valid = 1'b0;
    chars_if.ch    = '0;
    words_if.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed, at the reset limit of 64:
    // empty line -> done result with no word
    put_byte(CH_NUL);
    // leading blanks; unquoted word with 0xFF and a literal double quote, ended
    // by CR; single-quoted word with an inner space; empty double-quoted word;
    // a word ended by LF; open word flushed by the terminator
    put_byte(CH_SP);     put_byte(CH_TAB);    put_byte(8'h61);  put_byte(8'hFF);
    put_byte(CH_DQ);     put_byte(8'h01);     put_byte(CH_CR);  put_byte(CH_SQ);
    put_byte(8'h78);     put_byte(CH_SP);     put_byte(8'h79);  put_byte(CH_SQ);
    put_byte(8'h0B);     put_byte(CH_DQ);     put_byte(CH_DQ);  put_byte(8'h0C);
    put_byte(8'h7A);     put_byte(8'h0A);     put_byte(8'h80);  put_byte(CH_NUL);
    // quoted word left open at the terminator
    put_byte(CH_SQ);     put_byte(8'h41);     put_byte(CH_SP);  put_byte(CH_NUL);

    write_max_args(1);
    put_random_lines(60, 1'b0);

    // Long receiver hold-off while the sender keeps going.
    write_max_args(64);
    hold_req = 1'b1;
    put_random_lines(120, 1'b0);

    // Out-of-range limits: 0 extracts nothing, 127 acts as 64.
    write_max_args(0);
    put_random_lines(25, 1'b0);
    write_max_args(127);
    put_random_lines(40, 1'b0);

    // Limit changed between bytes of one line.
    write_max_args(3);
    put_random_lines(60, 1'b1);
    write_max_args(5);
    put_random_lines(60, 1'b0);

    // Overlong line: one word filling every offset but the last, ended by a blank at the
    // saturated offset, then a quote there that opens an empty word.
    write_max_args(64);
    for (k = 0; k < POS_LAST; k++) put_byte(8'h6B);
    put_byte(CH_SP);
    put_byte(CH_DQ);
    put_byte(8'h6D);
    put_byte(CH_NUL);

    wait_idle();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
